/* hdl/hashed_page_table_core_macros.svh */
// assertion macros shared by the hashed page table core
`ifndef HASHED_PAGE_TABLE_CORE_MACROS_SVH
`define HASHED_PAGE_TABLE_CORE_MACROS_SVH

// same-cycle implication
`define HPT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HPT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/hpt_pkg.sv */
// types, codes and default sizes of the hashed page table core
package hpt_pkg;

  localparam int BUCKETS_DEF        = 1024;
  localparam int OVERFLOW_NODES_DEF = 1024;
  localparam int ID_BITS_DEF        = 8;
  localparam int PAGE_SHIFT_DEF     = 12;

  localparam int VA_W   = 32;
  localparam int WORD_W = 32;
  localparam int SID_W  = 8;

  localparam int HASH_W_DEF = (ID_BITS_DEF > VA_W - PAGE_SHIFT_DEF) ?
                              ID_BITS_DEF : VA_W - PAGE_SHIFT_DEF;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_UPDATE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_NO_MEMORY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_CLEAR,
    WR_INVALIDATE,
    WR_WORD,
    WR_FILL,
    WR_LINK,
    WR_FRESH
  } wr_kind_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_EVAL,
    S_APPEND,
    S_DONE
  } state_t;

  typedef struct packed {
    logic     req_ready;
    logic     hash_start;
    logic     rd_head;
    logic     rd_next;
    wr_kind_t wr;
    logic     pool_inc;
    logic     res_load;
    status_t  res_status;
    logic     res_take_word;
    logic     out_load;
    logic     clr_step;
  } cmd_t;

  typedef struct packed {
    logic req_valid;
    op_t  op;
    logic hash_done;
    logic hit;
    logic node_valid;
    logic has_next;
    logic pool_full;
    logic out_free;
    logic clr_last;
  } stat_t;

endpackage

/* hdl/hpt_if.sv */
// request and response channel interfaces
interface hpt_req_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 operation;
  logic [hpt_pkg::SID_W-1:0]  space_id;
  logic [hpt_pkg::VA_W-1:0]   virtual_address;
  logic [hpt_pkg::WORD_W-1:0] translation_word;

  modport source (output valid, operation, space_id, virtual_address, translation_word,
                  input ready);
  modport sink (input valid, operation, space_id, virtual_address, translation_word,
                output ready);
endinterface

interface hpt_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [hpt_pkg::WORD_W-1:0] found_word;
  logic [1:0]                 status;

  modport source (output valid, found_word, status, input ready);
  modport sink (input valid, found_word, status, output ready);
endinterface

/* hdl/hpt_ram.sv */
// generic single-port-write ram with registered read
module hpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/hpt_hash.sv */
// bucket index unit: key modulo bucket count, masked or by reciprocal multiply
module hpt_bucket_index #(
  parameter int BUCKETS = hpt_pkg::BUCKETS_DEF,
  parameter int X_W     = hpt_pkg::HASH_W_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [X_W-1:0]             x,
  output logic                       done,
  output logic [$clog2(BUCKETS)-1:0] head
);

  localparam int  HEAD_W = $clog2(BUCKETS);
  localparam bit  POW2   = (BUCKETS & (BUCKETS - 1)) == 0;

  generate
    if (POW2) begin : g_mask
      logic busy;

      assign done = busy;

      always_ff @(posedge clk) begin
        if (rst) begin
          busy <= 1'b0;
        end else if (start) begin
          busy <= 1'b1;
        end else if (done) begin
          busy <= 1'b0;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          head <= HEAD_W'(x);
        end
      end
    end else begin : g_recip
      localparam int S_W = X_W + HEAD_W;
      localparam int P_W = 2 * X_W + 1;
      localparam longint unsigned RECIP =
        ((64'd1 << S_W) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);

      logic [2:0]     stage;
      logic [X_W-1:0] x_q;
      logic [P_W-1:0] prod;
      logic [X_W-1:0] quot_b;

      // quotient from the reciprocal product, times the bucket count
      assign done   = stage[2];
      assign quot_b = X_W'(prod[P_W-1:S_W]) * X_W'(BUCKETS);

      always_ff @(posedge clk) begin
        if (rst) begin
          stage <= '0;
        end else begin
          stage <= {stage[1:0], start};
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          x_q <= x;
        end
        if (stage[0]) begin
          prod <= P_W'(x_q) * P_W'(RECIP);
        end
        if (stage[1]) begin
          head <= HEAD_W'(x_q - quot_b);
        end
      end
    end
  endgenerate

endmodule

/* hdl/hpt_ctrl.sv */
// request sequencer of the hashed page table
module hpt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  hpt_pkg::stat_t stat,
  output hpt_pkg::cmd_t  cmd
);

  hpt_pkg::state_t state;
  hpt_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hpt_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      hpt_pkg::S_CLEAR: begin
        cmd.clr_step = 1'b1;
        cmd.wr       = hpt_pkg::WR_CLEAR;
        if (stat.clr_last) begin
          state_next = hpt_pkg::S_IDLE;
        end
      end
      hpt_pkg::S_IDLE: begin
        cmd.req_ready = 1'b1;
        if (stat.req_valid) begin
          cmd.hash_start = 1'b1;
          state_next     = hpt_pkg::S_HASH;
        end
      end
      hpt_pkg::S_HASH: begin
        if (stat.hash_done) begin
          cmd.rd_head = 1'b1;
          state_next  = hpt_pkg::S_EVAL;
        end
      end
      hpt_pkg::S_EVAL: begin
        if (stat.op == hpt_pkg::OP_INSERT) begin
          if (!stat.node_valid) begin
            cmd.wr         = hpt_pkg::WR_FILL;
            cmd.res_load   = 1'b1;
            cmd.res_status = hpt_pkg::ST_OK;
            state_next     = hpt_pkg::S_DONE;
          end else if (stat.has_next) begin
            cmd.rd_next = 1'b1;
          end else if (stat.pool_full) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = hpt_pkg::ST_NO_MEMORY;
            state_next     = hpt_pkg::S_DONE;
          end else begin
            cmd.wr     = hpt_pkg::WR_LINK;
            state_next = hpt_pkg::S_APPEND;
          end
        end else if (stat.hit) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = hpt_pkg::ST_OK;
          state_next     = hpt_pkg::S_DONE;
          case (stat.op)
            hpt_pkg::OP_LOOKUP: cmd.res_take_word = 1'b1;
            hpt_pkg::OP_DELETE: cmd.wr = hpt_pkg::WR_INVALIDATE;
            hpt_pkg::OP_UPDATE: cmd.wr = hpt_pkg::WR_WORD;
            default: ;
          endcase
        end else if (stat.has_next) begin
          cmd.rd_next = 1'b1;
        end else begin
          cmd.res_load   = 1'b1;
          cmd.res_status = hpt_pkg::ST_NOT_FOUND;
          state_next     = hpt_pkg::S_DONE;
        end
      end
      hpt_pkg::S_APPEND: begin
        cmd.wr         = hpt_pkg::WR_FRESH;
        cmd.pool_inc   = 1'b1;
        cmd.res_load   = 1'b1;
        cmd.res_status = hpt_pkg::ST_OK;
        state_next     = hpt_pkg::S_DONE;
      end
      hpt_pkg::S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = hpt_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = hpt_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* hdl/hpt_datapath.sv */
// request registers, node store, pool counter and response register
module hpt_datapath #(
  parameter int BUCKETS        = hpt_pkg::BUCKETS_DEF,
  parameter int OVERFLOW_NODES = hpt_pkg::OVERFLOW_NODES_DEF,
  parameter int ID_BITS        = hpt_pkg::ID_BITS_DEF,
  parameter int PAGE_SHIFT     = hpt_pkg::PAGE_SHIFT_DEF
) (
  input  logic           clk,
  input  logic           rst,
  hpt_req_if.sink        req,
  hpt_rsp_if.source      rsp,
  input  hpt_pkg::cmd_t  cmd,
  output hpt_pkg::stat_t stat
);

  localparam int TOTAL   = BUCKETS + OVERFLOW_NODES;
  localparam int NODE_W  = $clog2(TOTAL);
  localparam int HEAD_W  = $clog2(BUCKETS);
  localparam int POOL_W  = $clog2(OVERFLOW_NODES + 1);
  localparam int PAGE_W  = hpt_pkg::VA_W - PAGE_SHIFT;
  localparam int TAG_W   = ID_BITS + PAGE_W;
  localparam int X_W     = (ID_BITS > PAGE_W) ? ID_BITS : PAGE_W;
  localparam int WORD_W  = hpt_pkg::WORD_W;
  localparam int REC_W   = 2 + NODE_W + TAG_W + WORD_W;

  // request registers
  hpt_pkg::op_t        q_op;
  logic [ID_BITS-1:0]  q_id;
  logic [PAGE_W-1:0]   q_page;
  logic [WORD_W-1:0]   q_word;
  logic [TAG_W-1:0]    q_tag;

  logic [NODE_W-1:0]   cur;
  logic [POOL_W-1:0]   pool_used;
  logic [NODE_W-1:0]   clr_addr;
  logic [NODE_W-1:0]   fresh;

  logic                hash_done;
  logic [HEAD_W-1:0]   head;

  // node record fields
  logic [REC_W-1:0]    rd_data;
  logic                r_valid;
  logic                r_has_next;
  logic [NODE_W-1:0]   r_next;
  logic [TAG_W-1:0]    r_tag;
  logic [WORD_W-1:0]   r_word;

  logic                ram_we;
  logic [NODE_W-1:0]   ram_waddr;
  logic [REC_W-1:0]    ram_wdata;
  logic [NODE_W-1:0]   ram_raddr;

  hpt_pkg::status_t    res_status;
  logic [WORD_W-1:0]   res_word;
  logic                out_valid;
  hpt_pkg::status_t    out_status;
  logic [WORD_W-1:0]   out_word;

  assign {r_valid, r_has_next, r_next, r_tag, r_word} = rd_data;
  assign q_tag = {q_id, q_page};
  assign fresh = NODE_W'(BUCKETS) + NODE_W'(pool_used);

  always_ff @(posedge clk) begin
    if (cmd.hash_start) begin
      q_op   <= hpt_pkg::op_t'(req.operation);
      q_id   <= ID_BITS'(req.space_id);
      q_page <= req.virtual_address[hpt_pkg::VA_W-1:PAGE_SHIFT];
      q_word <= req.translation_word;
    end
  end

  hpt_bucket_index #(
    .BUCKETS (BUCKETS),
    .X_W     (X_W)
  ) u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.hash_start),
    .x     (X_W'(ID_BITS'(req.space_id)) ^
            X_W'(req.virtual_address[hpt_pkg::VA_W-1:PAGE_SHIFT])),
    .done  (hash_done),
    .head  (head)
  );

  always_ff @(posedge clk) begin
    if (cmd.rd_head) begin
      cur <= NODE_W'(head);
    end else if (cmd.rd_next) begin
      cur <= r_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_used <= '0;
      clr_addr  <= '0;
    end else begin
      if (cmd.pool_inc) begin
        pool_used <= pool_used + 1'b1;
      end
      if (cmd.clr_step) begin
        clr_addr <= stat.clr_last ? '0 : clr_addr + 1'b1;
      end
    end
  end

  assign ram_raddr = cmd.rd_head ? NODE_W'(head) : r_next;
  assign ram_we    = (cmd.wr != hpt_pkg::WR_NONE);

  always_comb begin
    ram_waddr = cur;
    ram_wdata = '0;
    case (cmd.wr)
      hpt_pkg::WR_CLEAR: begin
        ram_waddr = clr_addr;
      end
      hpt_pkg::WR_INVALIDATE: begin
        ram_wdata = {1'b0, r_has_next, r_next, r_tag, r_word};
      end
      hpt_pkg::WR_WORD: begin
        ram_wdata = {1'b1, r_has_next, r_next, r_tag, q_word};
      end
      hpt_pkg::WR_FILL: begin
        ram_wdata = {1'b1, r_has_next, r_next, q_tag, q_word};
      end
      hpt_pkg::WR_LINK: begin
        ram_wdata = {r_valid, 1'b1, fresh, r_tag, r_word};
      end
      hpt_pkg::WR_FRESH: begin
        ram_waddr = fresh;
        ram_wdata = {1'b1, 1'b0, {NODE_W{1'b0}}, q_tag, q_word};
      end
      default: ;
    endcase
  end

  hpt_ram #(
    .WIDTH (REC_W),
    .DEPTH (TOTAL)
  ) u_nodes (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_head || cmd.rd_next),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_status <= cmd.res_status;
      res_word   <= cmd.res_take_word ? r_word : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= res_status;
      out_word   <= res_word;
    end
  end

  assign req.ready      = cmd.req_ready;
  assign rsp.valid      = out_valid;
  assign rsp.found_word = out_word;
  assign rsp.status     = out_status;

  assign stat.req_valid  = req.valid;
  assign stat.op         = q_op;
  assign stat.hash_done  = hash_done;
  assign stat.hit        = r_valid && (r_tag == q_tag);
  assign stat.node_valid = r_valid;
  assign stat.has_next   = r_has_next;
  assign stat.pool_full  = (pool_used == POOL_W'(OVERFLOW_NODES));
  assign stat.out_free   = !out_valid || rsp.ready;
  assign stat.clr_last   = (clr_addr == NODE_W'(TOTAL - 1));

endmodule

/* hdl/hashed_page_table_core.sv */
// top level of the hashed page table core
//
//   channel  dir  payload                                                 handshake
//   req      in   operation, space_id, virtual_address, translation_word  valid/ready
//   rsp      out  found_word, status                                      valid/ready
//
// after reset the node store is swept clear, one node per cycle, with req.ready low. a request
// then hashes its key to a bucket index, masked when BUCKETS is a power of two and otherwise
// by a reciprocal multiply, walks the bucket chain node by node, and for an insert that
// appends a pool node writes that fresh node in an extra append step.
// a finished transaction waits in the response register, so a new request is taken while
// rsp is stalled; the next result waits until that register frees.
`include "hashed_page_table_core_macros.svh"

module hashed_page_table_core #(
  parameter int BUCKETS        = hpt_pkg::BUCKETS_DEF,
  parameter int OVERFLOW_NODES = hpt_pkg::OVERFLOW_NODES_DEF,
  parameter int ID_BITS        = hpt_pkg::ID_BITS_DEF,
  parameter int PAGE_SHIFT     = hpt_pkg::PAGE_SHIFT_DEF
) (
  input logic       clk,
  input logic       rst,
  hpt_req_if.sink   req,
  hpt_rsp_if.source rsp
);

  hpt_pkg::cmd_t  cmd;
  hpt_pkg::stat_t stat;

  hpt_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  hpt_datapath #(
    .BUCKETS        (BUCKETS),
    .OVERFLOW_NODES (OVERFLOW_NODES),
    .ID_BITS        (ID_BITS),
    .PAGE_SHIFT     (PAGE_SHIFT)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .rsp  (rsp),
    .cmd  (cmd),
    .stat (stat)
  );

  `HPT_ASSERT_NOW(a_no_accept_in_clear, clk, rst, cmd.clr_step, !req.ready,
                  "request taken during clear sweep")
  `HPT_ASSERT_NOW(a_pool_bound, clk, rst, cmd.pool_inc, !stat.pool_full,
                  "overflow pool used past its end")
  `HPT_ASSERT_NOW(a_word_only_ok, clk, rst, rsp.valid && (rsp.found_word != '0),
                  rsp.status == hpt_pkg::ST_OK, "nonzero word with failing status")
  `HPT_ASSERT_NEXT(a_busy_after_accept, clk, rst, cmd.hash_start, !req.ready,
                   "second request taken while busy")

endmodule
